@@ src/bytekiller_backward_decruncher_top_defines.svh @@
// ----------------------------------------------------------------------------
// Backward decruncher assertion macros
// Assertion macros for the backward decruncher sequencer.
// ----------------------------------------------------------------------------
`ifndef BYTEKILLER_BACKWARD_DECRUNCHER_TOP_DEFINES_SVH
`define BYTEKILLER_BACKWARD_DECRUNCHER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BKD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BKD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BKD_ASSERT_IMP(label, ante, cons, msg)
`define BKD_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

@@ src/bkd_pkg.sv @@
// ----------------------------------------------------------------------------
// Backward decruncher package
// Types and constants shared by the backward decruncher modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package bkd_pkg;
    localparam int OFFSET_BITS = 12;
    localparam int WIN_DEPTH = 1 << OFFSET_BITS;
    localparam int POS_W = 17;
    localparam int MAX_OUTPUT = 131072;
    localparam logic [31:0] RES_MARK = 32'h8000_0000;

    typedef enum logic [1:0] {
        ST_ACCEPTED  = 2'd0,
        ST_BYTE      = 2'd1,
        ST_NEED_WORD = 2'd2,
        ST_DONE      = 2'd3
    } status_t;

    typedef struct packed {
        logic        take;
        logic        seed;
        logic        push;
        logic [31:0] word;
    } bit_req_t;

    typedef struct packed {
        logic avail;
        logic bit_value;
    } bit_rsp_t;
endpackage

@@ src/bkd_in_if.sv @@
// ----------------------------------------------------------------------------
// Backward decruncher input channel
// Valid/ready channel carrying a command and a packed word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface bkd_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] packed_word;

    modport source (output valid, cmd, packed_word, input ready);
    modport sink (input valid, cmd, packed_word, output ready);
endinterface

@@ src/bkd_out_if.sv @@
// ----------------------------------------------------------------------------
// Backward decruncher output channel
// Valid/ready channel carrying status, decoded byte and its position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface bkd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  out_byte;
    logic [16:0] out_position;

    modport source (output valid, status, out_byte, out_position, input ready);
    modport sink (input valid, status, out_byte, out_position, output ready);
endinterface

@@ src/bkd_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module bkd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ src/bkd_bitsrc.sv @@
// ----------------------------------------------------------------------------
// Bit reservoir
// Shifts command bits out LSB first and refills from the pending word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module bkd_bitsrc (
    input  logic              clk,
    input  logic              rst_n,
    input  bkd_pkg::bit_req_t req,
    output bkd_pkg::bit_rsp_t rsp
);
    logic [31:0] res_reg, res_next;
    logic [31:0] pend_reg, pend_next;
    logic        pv_reg, pv_next;
    logic        has_bits;

    assign has_bits = (res_reg[31:1] != 31'd0);
    assign rsp.avail = has_bits || pv_reg;
    assign rsp.bit_value = has_bits ? res_reg[0] : pend_reg[0];

    always_comb
    begin
        res_next = res_reg;
        pend_next = pend_reg;
        pv_next = pv_reg;
        if (req.seed)
        begin
            res_next = req.word;
        end
        else if (req.push)
        begin
            if (!pv_reg)
            begin
                pend_next = req.word;
                pv_next = 1'b1;
            end
        end
        else if (req.take)
        begin
            if (has_bits)
            begin
                res_next = {1'b0, res_reg[31:1]};
            end
            else if (pv_reg)
            begin
                res_next = bkd_pkg::RES_MARK | {1'b0, pend_reg[31:1]};
                pv_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
            pend_reg <= '0;
            pv_reg <= 1'b0;
        end
        else
        begin
            res_reg <= res_next;
            pend_reg <= pend_next;
            pv_reg <= pv_next;
        end
    end
endmodule

@@ src/bkd_ctrl.sv @@
// ----------------------------------------------------------------------------
// Decruncher sequencer
// Parses one command bit per cycle while the bit reservoir has bits and emits at most one byte per produce request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bytekiller_backward_decruncher_top_defines.svh"
module bkd_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [bkd_pkg::POS_W-1:0]           usize,
    bkd_in_if.sink                              in_ch,
    bkd_out_if.source                           out_ch,
    output bkd_pkg::bit_req_t                   breq,
    input  bkd_pkg::bit_rsp_t                   brsp,
    output logic                                ram_we,
    output logic [bkd_pkg::OFFSET_BITS-1:0]     ram_waddr,
    output logic [7:0]                          ram_wdata,
    output logic [bkd_pkg::OFFSET_BITS-1:0]     ram_raddr,
    input  logic [7:0]                          ram_rdata
);
    localparam int AW = bkd_pkg::OFFSET_BITS;
    localparam int PW = bkd_pkg::POS_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_BIT  = 5'b00010,
        S_READ = 5'b00100,
        S_EMIT = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    typedef enum logic [8:0] {
        PH_TAG     = 9'b000000001,
        PH_SECOND  = 9'b000000010,
        PH_SEL     = 9'b000000100,
        PH_LIT3    = 9'b000001000,
        PH_LIT8    = 9'b000010000,
        PH_CPY8    = 9'b000100000,
        PH_OFFSET  = 9'b001000000,
        PH_LITBYTE = 9'b010000000,
        PH_COPY    = 9'b100000000
    } phase_t;

    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [11:0]       acc_reg, acc_next;
    logic [3:0]        left_reg, left_next;
    logic [8:0]        run_reg, run_next;
    logic [AW-1:0]     off_reg, off_next;
    logic              copy_reg, copy_next;
    logic [PW-1:0]     wp_reg, wp_next;
    logic [PW-1:0]     size_reg, size_next;
    logic [1:0]        hws_reg, hws_next;
    logic              hit_reg, hit_next;
    bkd_pkg::status_t  status_reg, status_next;
    logic [7:0]        byte_reg, byte_next;
    logic [PW-1:0]     pos_reg, pos_next;

    logic [11:0]       acc_sh;
    logic [3:0]        left_dec;
    logic [PW-1:0]     wp_dec;
    logic [8:0]        run_dec;
    logic [PW-1:0]     fill_cnt;
    logic [PW-1:0]     clamped;

    assign acc_sh = {acc_reg[10:0], brsp.bit_value};
    assign left_dec = left_reg - 4'd1;
    assign wp_dec = wp_reg - PW'(1);
    assign run_dec = run_reg - 9'd1;
    assign fill_cnt = size_reg - wp_reg;
    assign clamped = ({1'b0, usize} > (PW + 1)'(bkd_pkg::MAX_OUTPUT)) ?
                     PW'(bkd_pkg::MAX_OUTPUT) : usize;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.status = status_reg;
    assign out_ch.out_byte = byte_reg;
    assign out_ch.out_position = pos_reg;

    assign ram_raddr = wp_dec[AW-1:0] + off_reg;
    assign ram_waddr = wp_dec[AW-1:0];
    assign ram_wdata = byte_reg;
    assign ram_we = (state_reg == S_EMIT);

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        acc_next = acc_reg;
        left_next = left_reg;
        run_next = run_reg;
        off_next = off_reg;
        copy_next = copy_reg;
        wp_next = wp_reg;
        size_next = size_reg;
        hws_next = hws_reg;
        hit_next = hit_reg;
        status_next = status_reg;
        byte_next = byte_reg;
        pos_next = pos_reg;
        breq = '0;
        breq.word = in_ch.packed_word;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    byte_next = 8'd0;
                    pos_next = '0;
                    state_next = S_OUT;
                    if (!in_ch.cmd)
                    begin
                        status_next = bkd_pkg::ST_ACCEPTED;
                        if (hws_reg == 2'd0)
                        begin
                            hws_next = 2'd1;
                        end
                        else if (hws_reg == 2'd1)
                        begin
                            breq.seed = 1'b1;
                            wp_next = clamped;
                            size_next = clamped;
                            hws_next = 2'd2;
                        end
                        else
                        begin
                            breq.push = 1'b1;
                        end
                    end
                    else if (hws_reg != 2'd2)
                    begin
                        status_next = bkd_pkg::ST_NEED_WORD;
                    end
                    else if (wp_reg == '0)
                    begin
                        status_next = bkd_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = S_BIT;
                    end
                end
            end
            S_BIT:
            begin
                if (phase_reg == PH_COPY)
                begin
                    hit_next = ({{(PW - AW){1'b0}}, off_reg - AW'(1)} < fill_cnt);
                    state_next = S_READ;
                end
                else if (!brsp.avail)
                begin
                    status_next = bkd_pkg::ST_NEED_WORD;
                    byte_next = 8'd0;
                    pos_next = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    breq.take = 1'b1;
                    if (phase_reg == PH_TAG)
                    begin
                        if (!brsp.bit_value)
                        begin
                            phase_next = PH_SECOND;
                        end
                        else
                        begin
                            phase_next = PH_SEL;
                            acc_next = '0;
                            left_next = 4'd2;
                        end
                    end
                    else if (phase_reg == PH_SECOND)
                    begin
                        acc_next = '0;
                        if (brsp.bit_value)
                        begin
                            run_next = 9'd2;
                            phase_next = PH_OFFSET;
                            left_next = 4'd8;
                        end
                        else
                        begin
                            phase_next = PH_LIT3;
                            left_next = 4'd3;
                        end
                    end
                    else if (left_reg == 4'd0)
                    begin
                        phase_next = PH_TAG;
                    end
                    else
                    begin
                        acc_next = acc_sh;
                        left_next = left_dec;
                        if (left_dec == 4'd0)
                        begin
                            unique case (phase_reg) inside
                                PH_SEL:
                                begin
                                    acc_next = '0;
                                    left_next = 4'd8;
                                    if (acc_sh < 12'd2)
                                    begin
                                        run_next = 9'(acc_sh) + 9'd3;
                                        phase_next = PH_OFFSET;
                                        left_next = 4'd9 + 4'(acc_sh);
                                    end
                                    else if (acc_sh == 12'd3)
                                    begin
                                        phase_next = PH_LIT8;
                                    end
                                    else
                                    begin
                                        phase_next = PH_CPY8;
                                    end
                                end
                                PH_LIT3, PH_LIT8:
                                begin
                                    run_next = 9'(acc_sh) +
                                               ((phase_reg == PH_LIT3) ? 9'd1 : 9'd9);
                                    copy_next = 1'b0;
                                    phase_next = PH_LITBYTE;
                                    acc_next = '0;
                                    left_next = 4'd8;
                                end
                                PH_CPY8:
                                begin
                                    run_next = 9'(acc_sh) + 9'd1;
                                    phase_next = PH_OFFSET;
                                    acc_next = '0;
                                    left_next = 4'(AW);
                                end
                                PH_OFFSET:
                                begin
                                    off_next = acc_sh[AW-1:0];
                                    copy_next = 1'b1;
                                    phase_next = PH_COPY;
                                end
                                PH_LITBYTE:
                                begin
                                    byte_next = acc_sh[7:0];
                                    state_next = S_EMIT;
                                end
                                default:
                                begin
                                    phase_next = PH_TAG;
                                end
                            endcase
                        end
                    end
                end
            end
            S_READ:
            begin
                byte_next = hit_reg ? ram_rdata : 8'd0;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                wp_next = wp_dec;
                pos_next = wp_dec;
                status_next = bkd_pkg::ST_BYTE;
                run_next = run_dec;
                if (run_dec == 9'd0 || wp_dec == '0)
                begin
                    run_next = 9'd0;
                    copy_next = 1'b0;
                    phase_next = PH_TAG;
                end
                else if (!copy_reg)
                begin
                    phase_next = PH_LITBYTE;
                    acc_next = '0;
                    left_next = 4'd8;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ch.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_TAG;
            acc_reg <= '0;
            left_reg <= '0;
            run_reg <= '0;
            off_reg <= '0;
            copy_reg <= 1'b0;
            wp_reg <= '0;
            size_reg <= '0;
            hws_reg <= '0;
            hit_reg <= 1'b0;
            status_reg <= bkd_pkg::ST_ACCEPTED;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            acc_reg <= acc_next;
            left_reg <= left_next;
            run_reg <= run_next;
            off_reg <= off_next;
            copy_reg <= copy_next;
            wp_reg <= wp_next;
            size_reg <= size_next;
            hws_reg <= hws_next;
            hit_reg <= hit_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        pos_reg <= pos_next;
    end

    `BKD_ASSERT_IMP(a_out_blocks_in, out_ch.valid, !in_ch.ready, "input taken while result held")
    `BKD_ASSERT_NXT(a_emit_to_out, state_reg == S_EMIT,
        state_reg == S_OUT && status_reg == bkd_pkg::ST_BYTE, "emit did not present a byte")
    `BKD_ASSERT_NXT(a_emit_step, state_reg == S_EMIT, wp_reg == $past(wp_dec),
        "write position did not step down")
    `BKD_ASSERT_IMP(a_pos_match, state_reg == S_OUT && status_reg == bkd_pkg::ST_BYTE,
        pos_reg == wp_reg, "byte position differs from write position")
endmodule

@@ src/bytekiller_backward_decruncher_top.sv @@
// ----------------------------------------------------------------------------
// Backward decruncher top level
// Decodes a backward packed stream, at most one byte per produce request.
// ----------------------------------------------------------------------------
// Channel   Direction  Carries
// in_ch     sink       cmd, packed_word
// out_ch    source     status, out_byte, out_position
//
// A supplied word goes from idle straight to its result; each request is one word.
// A produce request is accepted in the idle state, reads its command bits from
// the bit reservoir (up to 23), writes the history and then presents the
// result; a copy byte adds an address step and a history read before the write.
// The block takes no new word until the result is taken.
// Reset is asynchronous; the history needs no clearing pass after reset.
`timescale 1ns / 1ps
module bytekiller_backward_decruncher_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata,
    bkd_in_if.sink      in_ch,
    bkd_out_if.source   out_ch
);
    logic [bkd_pkg::POS_W-1:0]       usize_reg;
    bkd_pkg::bit_req_t               breq;
    bkd_pkg::bit_rsp_t               brsp;
    logic                            ram_we;
    logic [bkd_pkg::OFFSET_BITS-1:0] ram_waddr;
    logic [bkd_pkg::OFFSET_BITS-1:0] ram_raddr;
    logic [7:0]                      ram_wdata;
    logic [7:0]                      ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            usize_reg <= '0;
        end
        else if (cfg_we)
        begin
            usize_reg <= cfg_wdata;
        end
    end

    bkd_bitsrc u_bitsrc (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (breq),
        .rsp   (brsp)
    );

    bkd_ram #(
        .WIDTH (8),
        .DEPTH (bkd_pkg::WIN_DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bkd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .usize     (usize_reg),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .breq      (breq),
        .brsp      (brsp),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );
endmodule
